// File: hdl/swm_pkg.sv
// Package for the sliding window minimum/maximum core.
// Holds shared widths, reset values and parameter defaults; no dependencies.
package swm_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int                    WINDOW_LEN_W   = 7;
	localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RST = 7'd64;

endpackage

// File: hdl/swm_cell.sv
// One cell of the window chain: holds one sample and folds it into the passing min/max.
// Depends on swm_pkg for parameter defaults.
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   load,
	input  logic                   active,
	input  logic [SAMPLE_BITS-1:0] sample_left,
	output logic [SAMPLE_BITS-1:0] sample_out,
	input  logic                   tok_in,
	input  logic [SAMPLE_BITS-1:0] max_in,
	input  logic [SAMPLE_BITS-1:0] min_in,
	output logic                   tok_out,
	output logic [SAMPLE_BITS-1:0] max_out,
	output logic [SAMPLE_BITS-1:0] min_out
);
	import swm_pkg::*;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic                   tok_q;
	logic [SAMPLE_BITS-1:0] cur;
	logic [SAMPLE_BITS-1:0] max_nxt;
	logic [SAMPLE_BITS-1:0] min_nxt;

	// A sample that is being shifted in this cycle is already part of the window.
	assign cur = load ? sample_left : sample_q;

	always_comb begin
		max_nxt = max_in;
		min_nxt = min_in;
		if (active) begin
			if ($signed(cur) > $signed(max_in)) begin
				max_nxt = cur;
			end
			if ($signed(cur) < $signed(min_in)) begin
				min_nxt = cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (en) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= sample_left;
		end
		if (en && tok_in) begin
			max_q <= max_nxt;
			min_q <= min_nxt;
		end
	end

	assign sample_out = sample_q;
	assign tok_out    = tok_q;
	assign max_out    = max_q;
	assign min_out    = min_q;

endmodule

// File: hdl/sliding_window_min_max_core.sv
// Top level of the sliding window minimum/maximum core: control, fill count and cell chain.
// Depends on swm_pkg and swm_cell.
//
// Channel   Signals                          Contents
// s_axis    tvalid tready tdata tuser        sample in, restart flag
// m_axis    tvalid tready tdata              window maximum and minimum
// cfg       valid ready data                 window length register
//
// Each sample's result is offered on m_axis once one fold token, started when its request is
// accepted, has walked the chain one cell per cycle while the chain is not held and left the last cell.
// s_axis_tready stays low until then, so no new sample is taken while one is still being folded.
// Reset clears the fill count, the tokens and the output valid and sets the window to 64.
// A fold that finishes while the previous result still waits on m_axis holds in the last
// cell until that result is taken.
module sliding_window_min_max_core #(
	parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// Bits from 0: sample.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
	// Bits from 0: restart.
	input  logic [0:0]                                s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// Bits from 0: window_max, window_min.
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [swm_pkg::WINDOW_LEN_W-1:0]          cfg_data
);
	import swm_pkg::*;

	localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int LW    = (CNT_W > WINDOW_LEN_W) ? CNT_W : WINDOW_LEN_W;

	logic [WINDOW_LEN_W-1:0] window_len_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  out_max_q;
	logic [SAMPLE_BITS-1:0]  out_min_q;

	logic [SAMPLE_BITS-1:0] samp [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] agg_max [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] agg_min [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  tok;

	logic                   accept;
	logic                   adv;
	logic                   done;
	logic [SAMPLE_BITS-1:0] in_sample;
	logic [LW-1:0]          len_ext;
	logic [CNT_W-1:0]       eff_len;
	logic [CNT_W-1:0]       fill_base;
	logic [CNT_W-1:0]       fill_nxt;

	assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// The chain only stops when the finished result cannot leave the last cell.
	assign done = tok[MAX_WINDOW-1];
	assign adv  = !(done && out_valid_q && !m_axis_tready);

	always_comb begin
		len_ext = LW'(window_len_q);
		if (len_ext == '0) begin
			len_ext = LW'(1);
		end else if (len_ext > LW'(MAX_WINDOW)) begin
			len_ext = LW'(MAX_WINDOW);
		end
		eff_len   = CNT_W'(len_ext);
		fill_base = s_axis_tuser[0] ? '0 : fill_q;
		fill_nxt  = (fill_base < eff_len) ? fill_base + CNT_W'(1) : eff_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			fill_q       <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_len_q <= cfg_data;
			end
			if (accept) begin
				fill_q <= fill_nxt;
				busy_q <= 1'b1;
			end else if (done && adv) begin
				busy_q <= 1'b0;
			end
			if (done && adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && adv) begin
			out_max_q <= agg_max[MAX_WINDOW-1];
			out_min_q <= agg_min[MAX_WINDOW-1];
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			logic [SAMPLE_BITS-1:0] left_s;
			logic [SAMPLE_BITS-1:0] left_max;
			logic [SAMPLE_BITS-1:0] left_min;
			logic                   left_tok;
			logic                   act;

			if (gi == 0) begin : g_head
				assign left_s   = in_sample;
				assign left_max = in_sample;
				assign left_min = in_sample;
				assign left_tok = accept;
				assign act      = 1'b1;
			end else begin : g_body
				assign left_s   = samp[gi-1];
				assign left_max = agg_max[gi-1];
				assign left_min = agg_min[gi-1];
				assign left_tok = tok[gi-1];
				assign act      = (CNT_W'(gi) < fill_q);
			end

			swm_cell #(
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.en          (adv),
				.load        (accept),
				.active      (act),
				.sample_left (left_s),
				.sample_out  (samp[gi]),
				.tok_in      (left_tok),
				.max_in      (left_max),
				.min_in      (left_min),
				.tok_out     (tok[gi]),
				.max_out     (agg_max[gi]),
				.min_out     (agg_min[gi])
			);
		end
	endgenerate

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_min_q, out_max_q});

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok))
		else $error("more than one fold token in the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok == '0))
		else $error("fold token present while idle");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (tok[0] && busy_q))
		else $error("accepted sample did not start a fold");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fill_q != '0 && fill_q <= CNT_W'(MAX_WINDOW)))
		else $error("fill count out of range");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(out_max_q) >= $signed(out_min_q)))
		else $error("window maximum below window minimum");

endmodule

// File: test/sliding_window_min_max_core_tb.sv
// Self-checking testbench for sliding_window_min_max_core: random and directed sample requests
// are checked against a behavioral window predictor under random back-pressure.
// Depends on swm_pkg and the core RTL only.
module sliding_window_min_max_core_tb;

	localparam int SB = swm_pkg::SAMPLE_BITS_DEF;
	localparam int MW = swm_pkg::MAX_WINDOW_DEF;
	localparam int SDW = ((SB + 7) / 8) * 8;
	localparam int MDW = ((2 * SB + 7) / 8) * 8;
	localparam int LW = swm_pkg::WINDOW_LEN_W;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		logic          restart;
		logic [SB-1:0] sample;
	} sample_req_t;

	typedef struct packed {
		logic [SB-1:0] wmax;
		logic [SB-1:0] wmin;
	} window_result_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [SDW-1:0] s_axis_tdata = '0;
	logic [0:0]     s_axis_tuser = '0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [MDW-1:0] m_axis_tdata;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [LW-1:0]  cfg_data = '0;

	sample_req_t    pending_samples[$];
	window_result_t expected_windows[$];
	int             items_queued = 0;
	int             results_seen = 0;
	int             error_count = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	// Predictor state.
	logic signed [SB-1:0] hist [MW];
	int unsigned          fill_cnt = 0;
	int unsigned          wr_ptr = 0;
	logic [LW-1:0]        win_len = swm_pkg::WINDOW_LEN_RST;

	logic [LW-1:0] phase_len [N_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd5,
		7'd63, 7'd17, 7'd33};

	sliding_window_min_max_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("sliding_window_min_max_core regression: fail");
		$finish;
	end

	function automatic window_result_t predict_window(input logic restart,
		input logic signed [SB-1:0] s);
		int unsigned          span;
		int unsigned          k;
		int unsigned          idx;
		logic signed [SB-1:0] hi;
		logic signed [SB-1:0] lo;
		window_result_t       r;
		span = (win_len == 0) ? 1 : ((win_len > MW) ? MW : win_len);
		if (restart) begin
			fill_cnt = 0;
		end
		hist[wr_ptr] = s;
		if (fill_cnt < span) begin
			fill_cnt++;
		end
		if (fill_cnt > span) begin
			fill_cnt = span;
		end
		hi = s;
		lo = s;
		for (k = 1; k < fill_cnt; k++) begin
			idx = (wr_ptr + MW - k) % MW;
			if (hist[idx] > hi) begin
				hi = hist[idx];
			end
			if (hist[idx] < lo) begin
				lo = hist[idx];
			end
		end
		wr_ptr = (wr_ptr + 1) % MW;
		r.wmax = hi;
		r.wmin = lo;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [SB-1:0] got,
		input logic [SB-1:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	// Sample request driver.
	always @(posedge clk or negedge arst_n) begin
		sample_req_t req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_windows.insert(expected_windows.size(),
					predict_window(s_axis_tuser[0], s_axis_tdata[SB-1:0]));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req = pending_samples.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= SDW'(req.sample);
					s_axis_tuser <= req.restart;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		window_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_windows.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[SB-1:0], '0);
				end else begin
					want = expected_windows.pop_front();
					if (m_axis_tdata[SB-1:0] !== want.wmax) begin
						report_mismatch("window_max", m_axis_tdata[SB-1:0], want.wmax);
					end
					if (m_axis_tdata[2*SB-1:SB] !== want.wmin) begin
						report_mismatch("window_min", m_axis_tdata[2*SB-1:SB], want.wmin);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_sample(input logic restart, input logic [SB-1:0] s);
		sample_req_t req;
		req.restart = restart;
		req.sample = s;
		pending_samples.insert(pending_samples.size(), req);
		items_queued++;
	endtask

	task automatic wait_all_results();
		while (results_seen < items_queued) begin
			@(posedge clk);
		end
	endtask

	task automatic write_window_len(input logic [LW-1:0] len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_len = len;
	endtask

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(7))
			0: return {1'b0, {(SB-1){1'b1}}};
			1: return {1'b1, {(SB-1){1'b0}}};
			2: return SB'($urandom_range(16)) - SB'(8);
			3: return {SB{$urandom_range(1) == 1}};
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic queue_runs(input int count, input int span);
		int n;
		int run_len;
		int k;
		n = 0;
		while (n < count) begin
			run_len = ($urandom_range(9) == 0) ? $urandom_range(3 * MW) + 1
				: $urandom_range(2 * span + 8) + 1;
			for (k = 0; k < run_len && n < count; k++) begin
				// Most runs open with a restart; a few continue the previous window.
				queue_sample(k == 0 && $urandom_range(99) < 85, pick_sample());
				n++;
			end
		end
	endtask

	initial begin
		int p;
		int span;
		for (p = 0; p < MW; p++) begin
			hist[p] = '0;
		end
		send_idle_pct = 23;
		recv_idle_pct = 87;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_sample(1'b1, {1'b0, {(SB-1){1'b1}}});
		queue_sample(1'b0, {1'b1, {(SB-1){1'b0}}});
		queue_sample(1'b0, '0);
		queue_sample(1'b0, '1);
		queue_sample(1'b0, SB'(1));
		queue_sample(1'b1, SB'(-5));
		queue_sample(1'b0, SB'(7));
		queue_sample(1'b0, SB'(-100));
		queue_sample(1'b0, SB'(3));
		queue_sample(1'b0, SB'(42));
		queue_sample(1'b0, SB'(-1));
		queue_sample(1'b1, SB'(9));
		wait_all_results();
		write_window_len(7'd3);
		queue_sample(1'b0, SB'(2));
		queue_sample(1'b0, SB'(1));
		queue_sample(1'b0, SB'(0));
		queue_sample(1'b0, SB'(-2));
		wait_all_results();
		write_window_len(7'd0);
		queue_sample(1'b0, {1'b0, {(SB-1){1'b1}}});
		queue_sample(1'b0, {1'b1, {(SB-1){1'b0}}});
		queue_sample(1'b1, SB'(5));
		wait_all_results();
		write_window_len(7'd127);
		queue_sample(1'b1, SB'(11));
		queue_sample(1'b0, SB'(-11));
		queue_sample(1'b0, SB'(4));
		wait_all_results();

		for (p = 0; p < N_PHASES; p++) begin
			if (p == 4) begin
				send_idle_pct = 87;
				recv_idle_pct = 23;
			end else if (p == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_window_len((p == N_PHASES - 1) ? LW'($urandom_range(127)) : phase_len[p]);
			span = (win_len == 0) ? 1 : ((win_len > MW) ? MW : win_len);
			queue_runs(PHASE_ITEMS / 2, span);
			wait_all_results();
			queue_runs(PHASE_ITEMS - PHASE_ITEMS / 2, span);
			wait_all_results();
		end

		repeat (2 * MW + 10) @(posedge clk);
		if (expected_windows.size() != 0) begin
			report_mismatch("expectations left over", SB'(expected_windows.size()), '0);
		end
		if (error_count == 0) begin
			$display("sliding_window_min_max_core regression: pass");
		end else begin
			$display("sliding_window_min_max_core regression: fail");
		end
		$finish;
	end

endmodule

// File: sliding_window_min_max_core.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_min_max_core.sv
test/sliding_window_min_max_core_tb.sv
